>>> rtl/core/cscan_disk_scheduler_unit_assert.svh
// assertion macros for the c-scan scheduler
// expect clk and rst_n in scope at the point of use
`ifndef CSCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH
`define CSCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define CSCAN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSCAN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cscan_pkg.sv
`timescale 1ns / 1ps

package cscan_pkg;

    // cylinder number width, fixes the largest disk at 2^CYL_BITS cylinders
    localparam int CYL_BITS  = 16;
    localparam int CYL_W     = CYL_BITS;
    localparam int CYLS_W    = CYL_BITS + 1;
    localparam int MOVE_W    = 18;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYLINDERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP       = 2'd2;

    localparam logic [CYL_W-1:0]  START_HEAD_RST     = '0;
    localparam logic [CYLS_W-1:0] DISK_CYLINDERS_RST = 17'h10000;
    localparam logic              SWEEP_UP_RST       = 1'b1;

    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             last_request;
    } request_t;

    typedef struct packed {
        logic [CYL_W-1:0]  served_cylinder;
        logic [MOVE_W-1:0] movement_so_far;
        logic              final_served;
    } result_t;

    typedef struct packed {
        logic [CYL_W-1:0]  start_head;
        logic [CYLS_W-1:0] disk_cylinders;
        logic              sweep_up;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EMIT_CHK,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_TRAVEL_END,
        ST_TRAVEL_JUMP
    } state_t;

endpackage

>>> rtl/core/cscan_store.sv
`timescale 1ns / 1ps

module cscan_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [cscan_pkg::CYL_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [cscan_pkg::CYL_W-1:0] rdata
);

    logic [cscan_pkg::CYL_W-1:0] mem [DEPTH];
    logic [cscan_pkg::CYL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/cscan_move.sv
`timescale 1ns / 1ps

module cscan_move (
    input  logic [cscan_pkg::CYL_W-1:0]  head,
    input  logic [cscan_pkg::CYL_W-1:0]  target,
    input  logic [cscan_pkg::MOVE_W-1:0] acc,
    output logic [cscan_pkg::MOVE_W-1:0] sum
);

    logic [cscan_pkg::CYL_W-1:0]  travel;
    logic [cscan_pkg::MOVE_W:0]   total;

    always_comb
    begin
        travel = (head > target) ? (head - target) : (target - head);
        total  = {1'b0, acc} + (cscan_pkg::MOVE_W + 1)'(travel);
        // saturate at all ones
        sum    = total[cscan_pkg::MOVE_W] ? '1 : total[cscan_pkg::MOVE_W-1:0];
    end

endmodule

>>> rtl/core/cscan_seq.sv
`timescale 1ns / 1ps

module cscan_seq #(
    parameter int MAX_REQUESTS = 32,
    parameter int AW           = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cscan_pkg::cfg_t              cfg,
    input  logic                         request_valid,
    output logic                         request_stall,
    input  cscan_pkg::request_t          request_item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output cscan_pkg::result_t           result_item,
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [cscan_pkg::CYL_W-1:0]  mem_wdata,
    output logic [AW-1:0]                mem_raddr,
    input  logic [cscan_pkg::CYL_W-1:0]  mem_rdata,
    output logic [cscan_pkg::CYL_W-1:0]  mv_head,
    output logic [cscan_pkg::CYL_W-1:0]  mv_target,
    output logic [cscan_pkg::MOVE_W-1:0] mv_acc,
    input  logic [cscan_pkg::MOVE_W-1:0] mv_sum
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam logic [cscan_pkg::CYLS_W-1:0] CYL_CAP = {1'b1, {cscan_pkg::CYL_W{1'b0}}};

    cscan_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] split_reg, split_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] emitted_reg, emitted_next;
    logic          phase_b_reg, phase_b_next;
    logic          last_reg, last_next;
    logic          out_valid_reg, out_valid_next;

    logic [cscan_pkg::CYL_W-1:0]  val_reg, val_next;
    logic [cscan_pkg::CYL_W-1:0]  head_reg, head_next;
    logic [cscan_pkg::MOVE_W-1:0] move_reg, move_next;
    cscan_pkg::result_t           out_item_reg, out_item_next;

    logic [cscan_pkg::CYLS_W-1:0] cyls_one, cyls_cap, top_wide;
    logic [cscan_pkg::CYL_W-1:0]  top;
    logic [cscan_pkg::CYL_W-1:0]  clamped;
    logic [CW-1:0]                j_dec, pos_dec, pos_inc;
    logic [CW-1:0]                count_inc, split_inc, emitted_inc;
    logic                         batch_end;
    logic                         finish;

    // top cylinder and clamp of the incoming request
    always_comb
    begin
        cyls_one = (cfg.disk_cylinders == '0) ? 17'd1 : cfg.disk_cylinders;
        cyls_cap = (cyls_one > CYL_CAP) ? CYL_CAP : cyls_one;
        top_wide = cyls_cap - 17'd1;
        top      = top_wide[cscan_pkg::CYL_W-1:0];
        clamped  = (request_item.request_cylinder > top) ? top
                                                         : request_item.request_cylinder;
    end

    always_comb
    begin
        j_dec       = j_reg - CW'(1);
        pos_dec     = pos_reg - CW'(1);
        pos_inc     = pos_reg + CW'(1);
        count_inc   = count_reg + CW'(1);
        split_inc   = (val_reg <= cfg.start_head) ? (split_reg + CW'(1)) : split_reg;
        emitted_inc = emitted_reg + CW'(1);
        batch_end   = last_reg || (count_inc == CW'(MAX_REQUESTS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cscan_pkg::ST_LOAD;
            count_reg     <= '0;
            split_reg     <= '0;
            j_reg         <= '0;
            pos_reg       <= '0;
            lim_reg       <= '0;
            emitted_reg   <= '0;
            phase_b_reg   <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            split_reg     <= split_next;
            j_reg         <= j_next;
            pos_reg       <= pos_next;
            lim_reg       <= lim_next;
            emitted_reg   <= emitted_next;
            phase_b_reg   <= phase_b_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        head_reg     <= head_next;
        move_reg     <= move_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        split_next     = split_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        lim_next       = lim_reg;
        emitted_next   = emitted_reg;
        phase_b_next   = phase_b_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        move_next      = move_reg;
        out_item_next  = out_item_reg;
        finish         = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = j_reg[AW-1:0];
        mem_wdata = val_reg;
        mem_raddr = j_dec[AW-1:0];
        mv_head   = head_reg;
        mv_target = mem_rdata;
        mv_acc    = move_reg;

        case (state_reg)
            cscan_pkg::ST_LOAD:
            begin
                if (request_valid)
                begin
                    val_next   = clamped;
                    last_next  = request_item.last_request;
                    j_next     = count_reg;
                    state_next = cscan_pkg::ST_INS_RD;
                end
            end

            // insertion: read the entry below the hole
            cscan_pkg::ST_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    mem_raddr  = j_dec[AW-1:0];
                    state_next = cscan_pkg::ST_INS_CMP;
                end
            end

            // shift the larger entry up or drop the new value in
            cscan_pkg::ST_INS_CMP:
            begin
                if (mem_rdata > val_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = j_reg[AW-1:0];
                    mem_wdata  = mem_rdata;
                    j_next     = j_dec;
                    state_next = cscan_pkg::ST_INS_RD;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            cscan_pkg::ST_EMIT_CHK:
            begin
                if (pos_reg != lim_reg)
                begin
                    mem_raddr  = cfg.sweep_up ? pos_reg[AW-1:0] : pos_dec[AW-1:0];
                    state_next = cscan_pkg::ST_EMIT_RD;
                end
                else if (!phase_b_reg)
                begin
                    state_next = cscan_pkg::ST_TRAVEL_END;
                end
                else
                begin
                    count_next = '0;
                    split_next = '0;
                    state_next = cscan_pkg::ST_LOAD;
                end
            end

            cscan_pkg::ST_EMIT_RD:
            begin
                mv_target      = mem_rdata;
                head_next      = mem_rdata;
                move_next      = mv_sum;
                out_valid_next = 1'b1;
                out_item_next.served_cylinder = mem_rdata;
                out_item_next.movement_so_far = mv_sum;
                out_item_next.final_served    = (emitted_inc == count_reg);
                emitted_next   = emitted_inc;
                pos_next       = cfg.sweep_up ? pos_inc : pos_dec;
                state_next     = cscan_pkg::ST_EMIT_WAIT;
            end

            cscan_pkg::ST_EMIT_WAIT:
            begin
                if (!result_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = cscan_pkg::ST_EMIT_CHK;
                end
            end

            // travel to the far end of the sweep
            cscan_pkg::ST_TRAVEL_END:
            begin
                mv_target  = cfg.sweep_up ? top : '0;
                head_next  = mv_target;
                move_next  = mv_sum;
                state_next = cscan_pkg::ST_TRAVEL_JUMP;
            end

            // jump to the opposite end, then serve the other side
            cscan_pkg::ST_TRAVEL_JUMP:
            begin
                mv_target    = cfg.sweep_up ? '0 : top;
                head_next    = mv_target;
                move_next    = mv_sum;
                phase_b_next = 1'b1;
                pos_next     = cfg.sweep_up ? '0 : count_reg;
                lim_next     = split_reg;
                state_next   = cscan_pkg::ST_EMIT_CHK;
            end

            default:
            begin
                state_next = cscan_pkg::ST_LOAD;
            end
        endcase

        if (finish)
        begin
            mem_we     = 1'b1;
            mem_waddr  = j_reg[AW-1:0];
            mem_wdata  = val_reg;
            count_next = count_inc;
            split_next = split_inc;
            if (batch_end)
            begin
                head_next    = cfg.start_head;
                move_next    = '0;
                emitted_next = '0;
                phase_b_next = 1'b0;
                pos_next     = split_inc;
                lim_next     = cfg.sweep_up ? count_inc : '0;
                state_next   = cscan_pkg::ST_EMIT_CHK;
            end
            else
            begin
                state_next = cscan_pkg::ST_LOAD;
            end
        end
    end

    assign request_stall = (state_reg != cscan_pkg::ST_LOAD);
    assign result_valid  = out_valid_reg;
    assign result_item   = out_item_reg;

endmodule

>>> rtl/core/cscan_disk_scheduler_unit.sv
`timescale 1ns / 1ps

// c-scan disk scheduler: takes a batch of cylinder requests (the last one
// flagged, or the one that fills the store) and then returns them in c-scan
// service order, each with the cumulative head movement, the last one flagged
// final. each request is clamped to the top cylinder and insertion-sorted into
// a store with one write port and a registered read port: loading a request
// reads the stored entries from the top down, shifting up each one larger
// than it, then writes the request into the hole. after the batch ends, each
// result is read from the store, has its travel added by the one shared
// distance/saturating-add unit and is held until the result side takes it;
// the travel to the end of the sweep and the jump come between the two sides.
// the request channel is stalled from acceptance of a request until its
// insertion is done, and through the whole emission of a batch. the store
// needs no clearing pass after reset. configuration is written at any time
// through the cfg port (always ready); it must only change between batches.
module cscan_disk_scheduler_unit #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              request_valid,
    output logic                              request_stall,
    input  cscan_pkg::request_t               request_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output cscan_pkg::result_t                result_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cscan_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cscan_pkg::CYLS_W-1:0]      cfg_data
);

    `include "cscan_disk_scheduler_unit_assert.svh"

    // store address width, at least one bit
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    // configuration registers
    logic [cscan_pkg::CYL_W-1:0]  start_head_reg;
    logic [cscan_pkg::CYLS_W-1:0] disk_cylinders_reg;
    logic                         sweep_up_reg;
    cscan_pkg::cfg_t              cfg;

    // store port
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [cscan_pkg::CYL_W-1:0]  mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [cscan_pkg::CYL_W-1:0]  mem_rdata;

    // shared movement unit
    logic [cscan_pkg::CYL_W-1:0]  mv_head;
    logic [cscan_pkg::CYL_W-1:0]  mv_target;
    logic [cscan_pkg::MOVE_W-1:0] mv_acc;
    logic [cscan_pkg::MOVE_W-1:0] mv_sum;

    assign cfg_ready = 1'b1;

    // writes to an index past the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_head_reg     <= cscan_pkg::START_HEAD_RST;
            disk_cylinders_reg <= cscan_pkg::DISK_CYLINDERS_RST;
            sweep_up_reg       <= cscan_pkg::SWEEP_UP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cscan_pkg::CFG_START_HEAD:
                begin
                    start_head_reg <= cfg_data[cscan_pkg::CYL_W-1:0];
                end
                cscan_pkg::CFG_DISK_CYLINDERS:
                begin
                    disk_cylinders_reg <= cfg_data;
                end
                cscan_pkg::CFG_SWEEP_UP:
                begin
                    sweep_up_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = '{start_head:     start_head_reg,
                   disk_cylinders: disk_cylinders_reg,
                   sweep_up:       sweep_up_reg};

    // sorted request store
    cscan_store #(
        .DEPTH (MAX_REQUESTS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // distance plus saturating accumulate, shared by every head move
    cscan_move u_move (
        .head   (mv_head),
        .target (mv_target),
        .acc    (mv_acc),
        .sum    (mv_sum)
    );

    // insertion and emission sequencer, owns the result register
    cscan_seq #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .AW           (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request_item  (request_item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_item   (result_item),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .mv_head       (mv_head),
        .mv_target     (mv_target),
        .mv_acc        (mv_acc),
        .mv_sum        (mv_sum)
    );

    // no result pending while the block takes requests
    `CSCAN_ASSERT_NOW(a_load_no_result, !request_stall, !result_valid,
        "result pending while loading")

    // a new result only shows while requests are held off
    `CSCAN_ASSERT_NOW(a_result_busy, $rose(result_valid), request_stall,
        "result raised while taking requests")

    // nothing follows the final result of a batch
    `CSCAN_ASSERT_NEXT(a_final_last,
        result_valid && !result_stall && result_item.final_served, !result_valid,
        "result after final of batch")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import cscan_pkg::*;

    localparam int MAX_REQ     = 32;
    localparam int MOVE_MAX    = 262143;
    // the limit leaves a wide margin over the worst case of insertion, sender gaps,
    // emission and result stalls for the whole run
    localparam int CYCLE_LIMIT = 400000;
    // enough for one insertion to finish after the last result of a batch
    localparam int SETTLE      = 2 * MAX_REQ + 8;

    // index past the end of the register list, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 request_valid;
    logic                 request_stall;
    request_t             request_item;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CYLS_W-1:0]    cfg_data;

    // scheduler settings as the block should hold them
    logic [CYL_W-1:0]     model_start_head = START_HEAD_RST;
    logic [CYLS_W-1:0]    model_cyls       = DISK_CYLINDERS_RST;
    logic                 model_sweep_up   = SWEEP_UP_RST;

    // requests of the batch still being loaded, and services still to come out
    logic [CYL_W-1:0]     batch_cylinders[$];
    result_t              expected_services[$];

    int  fail_count         = 0;
    int  requests_sent      = 0;
    int  results_checked    = 0;
    int  batches_done       = 0;
    int  settings_done      = 0;
    int  cycle_count        = 0;
    int  result_hold_cycles = 0;
    bit  no_idle            = 1'b0;

    cscan_disk_scheduler_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request_item  (request_item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_item   (result_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // top cylinder after the size is forced into 1 .. 2^16
    function automatic int disk_top();
        int cyls;
        cyls = model_cyls;
        if (cyls == 0)
            cyls = 1;
        if (cyls > (1 << CYL_W))
            cyls = 1 << CYL_W;
        return cyls - 1;
    endfunction

    // cumulative movement after one more head travel, saturating
    function automatic int add_travel(int moved, int from_cyl, int to_cyl);
        int sum;
        sum = moved + ((from_cyl > to_cyl) ? from_cyl - to_cyl : to_cyl - from_cyl);
        return (sum > MOVE_MAX) ? MOVE_MAX : sum;
    endfunction

    // c-scan order of the loaded batch, each service with its running movement
    function automatic void predict_service_order();
        int      sorted[MAX_REQ];
        int      order[$];
        int      n, top, split, first_leg, end_cyl, jump_cyl, head, moved, v, i, j;
        result_t svc;
        n   = batch_cylinders.size();
        top = disk_top();
        // clamp into the disk, then insertion sort ascending
        for (i = 0; i < n; i++)
        begin
            v = batch_cylinders[i];
            if (v > top)
                v = top;
            j = i;
            while (j > 0 && sorted[j - 1] > v)
            begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
        end
        // first request strictly above the start head
        split = n;
        for (i = n - 1; i >= 0; i--)
            if (sorted[i] > model_start_head)
                split = i;
        if (model_sweep_up)
        begin
            for (i = split; i < n; i++)
                order.push_back(sorted[i]);
            for (i = 0; i < split; i++)
                order.push_back(sorted[i]);
            first_leg = n - split;
            end_cyl   = top;
            jump_cyl  = 0;
        end
        else
        begin
            for (i = split; i > 0; i--)
                order.push_back(sorted[i - 1]);
            for (i = n; i > split; i--)
                order.push_back(sorted[i - 1]);
            first_leg = split;
            end_cyl   = 0;
            jump_cyl  = top;
        end
        head  = model_start_head;
        moved = 0;
        for (i = 0; i < n; i++)
        begin
            // travel to the end of the sweep and the jump, paid before the second leg
            if (i == first_leg)
            begin
                moved = add_travel(moved, head, end_cyl);
                moved = add_travel(moved, end_cyl, jump_cyl);
                head  = jump_cyl;
            end
            moved = add_travel(moved, head, order[i]);
            head  = order[i];
            svc.served_cylinder = head[CYL_W-1:0];
            svc.movement_so_far = moved[MOVE_W-1:0];
            svc.final_served    = (i == n - 1);
            expected_services.push_back(svc);
        end
        batch_cylinders.delete();
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // cylinder mix: anywhere, on the disk, at the head, at the edges, beyond, near the head
    function automatic logic [CYL_W-1:0] pick_cylinder();
        int r, top, c;
        r   = $urandom_range(0, 99);
        top = disk_top();
        if (r < 35)
            c = $urandom_range(0, 65535);
        else if (r < 62)
            c = $urandom_range(0, top);
        else if (r < 72)
            c = model_start_head;
        else if (r < 79)
            c = top;
        else if (r < 85)
            c = 0;
        else if (r < 92)
            c = (top < 65535) ? $urandom_range(top + 1, 65535) : 65535;
        else
        begin
            c = model_start_head + $urandom_range(0, 6) - 3;
            if (c < 0)
                c = 0;
            if (c > 65535)
                c = 65535;
        end
        return c[CYL_W-1:0];
    endfunction

    // one request through the handshake, then into the predictor
    task automatic send_request(input logic [CYL_W-1:0] cyl, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_valid <= 1'b1;
        request_item  <= '{request_cylinder: cyl, last_request: is_last};
        @(posedge clk);
        while (request_stall)
            @(posedge clk);
        batch_cylinders.push_back(cyl);
        requests_sent++;
        if (is_last || batch_cylinders.size() == MAX_REQ)
        begin
            predict_service_order();
            batches_done++;
        end
    endtask

    // n random requests, the last one flagged; a full batch may go unflagged
    task automatic send_batch(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_request(pick_cylinder(),
                         (i == n - 1) ? ((n == MAX_REQ) ? 1'($urandom_range(0, 1)) : 1'b1)
                                      : 1'b0);
    endtask

    task automatic pause_until_drained();
        request_valid <= 1'b0;
        while (expected_services.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        pause_until_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CYLS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_START_HEAD:     model_start_head = data[CYL_W-1:0];
            CFG_DISK_CYLINDERS: model_cyls       = data;
            CFG_SWEEP_UP:       model_sweep_up   = data[0];
            default:            ;
        endcase
    endtask

    // new settings, only once the block has gone quiet
    task automatic set_config(input logic [CYL_W-1:0] head, input logic [CYLS_W-1:0] cyls,
                              input logic [CYLS_W-1:0] sweep_word, input bit poke_unused);
        wait_idle();
        if (poke_unused)
            write_reg(CFG_UNUSED, CYLS_W'($urandom));
        write_reg(CFG_START_HEAD, {1'($urandom_range(0, 1)), head});
        write_reg(CFG_DISK_CYLINDERS, cyls);
        write_reg(CFG_SWEEP_UP, sweep_word);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // settings out of reset: head at 0, full disk, sweeping up
    task automatic test_reset_config();
        send_request(16'd0, 1'b0);
        send_request(16'd65535, 1'b0);
        send_request(16'd1, 1'b0);
        send_request(16'd32768, 1'b1);
    endtask

    // requests past the top get clamped; a request at the head is on the low side
    task automatic test_clamp_both_directions();
        set_config(16'd100, 17'd200, 17'd1, 1'b1);
        send_request(16'd150, 1'b0);
        send_request(16'd250, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'd50, 1'b0);
        send_request(16'd199, 1'b1);
        set_config(16'd100, 17'd200, 17'd0, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'd300, 1'b0);
        send_request(16'd0, 1'b1);
    endtask

    // size zero acts as one cylinder, oversize saturates, head off the disk
    task automatic test_disk_size_extremes();
        set_config(16'd5, 17'd0, 17'd0, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd7, 1'b1);
        set_config(16'd65535, 17'h1ffff, 17'd1, 1'b0);
        send_request(16'd65535, 1'b1);
        set_config(16'd0, 17'd1, 17'd1, 1'b0);
        send_request(16'd3, 1'b1);
    endtask

    // nothing on the sweep side: the head still runs to the end and jumps
    task automatic test_empty_sweep_side();
        set_config(16'd1000, 17'h10000, 17'd0, 1'b0);
        send_request(16'd2000, 1'b0);
        send_request(16'd3000, 1'b1);
        set_config(16'd60000, 17'h10000, 17'd1, 1'b0);
        send_request(16'd10, 1'b0);
        send_request(16'd20, 1'b1);
    endtask

    // the request that fills the store closes the batch
    task automatic test_full_store();
        set_config(16'd40000, 17'h10000, 17'd1, 1'b0);
        send_batch(MAX_REQ);
        send_batch(3);
        set_config(16'd300, 17'd4096, 17'd0, 1'b0);
        send_batch(MAX_REQ);
    endtask

    // results held off for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        set_config(16'd20000, 17'd50000, 17'd1, 1'b0);
        result_hold_cycles = 300;
        send_batch(6);
        send_batch(6);
        send_batch(6);
    endtask

    // sender waits for every service of a batch before the next one
    task automatic test_pause_until_drained();
        int i;
        for (i = 0; i < 4; i++)
        begin
            send_batch($urandom_range(1, 5));
            pause_until_drained();
        end
    endtask

    // back to back on both sides
    task automatic test_no_idle();
        int i;
        set_config(16'd33000, 17'h10000, 17'd0, 1'b0);
        no_idle = 1'b1;
        for (i = 0; i < 5; i++)
            send_batch($urandom_range(1, 10));
        wait_idle();
        no_idle = 1'b0;
    endtask

    // random settings, each followed by a few batches of random content
    task automatic test_random_batches(input int target);
        int sent, phase_sent, n, r;
        logic [CYLS_W-1:0] cyls;
        logic [CYL_W-1:0]  head;
        logic [CYLS_W-1:0] sweep_word;
        sent = 0;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                cyls = 0;
            else if (r < 20)
                cyls = 1;
            else if (r < 30)
                cyls = 17'h10000;
            else if (r < 38)
                cyls = $urandom_range(65537, 131071);
            else if (r < 62)
                cyls = $urandom_range(2, 64);
            else
                cyls = $urandom_range(2, 65535);
            r = $urandom_range(0, 99);
            if (r < 15)
                head = 16'd0;
            else if (r < 25)
                head = 16'd65535;
            else if (r < 55 || cyls == 0 || cyls > 17'h10000)
                head = $urandom_range(0, 65535);
            else
                head = $urandom_range(0, cyls - 1);
            // upper bits of the sweep word are don't-care
            sweep_word = {16'($urandom_range(0, 3) == 0 ? $urandom : 0), 1'($urandom_range(0, 1))};
            set_config(head, cyls, sweep_word, $urandom_range(0, 9) == 0);
            phase_sent = 0;
            while (phase_sent < 30)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    n = $urandom_range(1, 6);
                else if (r < 90)
                    n = $urandom_range(7, 20);
                else if (r < 97)
                    n = $urandom_range(21, MAX_REQ - 1);
                else
                    n = MAX_REQ;
                send_batch(n);
                phase_sent += n;
            end
            sent += phase_sent;
        end
    endtask

    // result side: random stalls, plus a long hold when a test asks for one
    initial
    begin : result_side
        int  hold_left;
        int  run_left;
        int  r;
        bit  run_stalled;
        hold_left    = 0;
        run_left     = 0;
        run_stalled  = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_hold_cycles != 0)
            begin
                hold_left          = result_hold_cycles;
                result_hold_cycles = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (no_idle)
                result_stall <= 1'b0;
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    run_stalled = (r >= 55);
                    if (r < 55)
                        run_left = $urandom_range(1, 8);
                    else if (r < 85)
                        run_left = $urandom_range(1, 3);
                    else if (r < 97)
                        run_left = $urandom_range(4, 10);
                    else
                        run_left = $urandom_range(20, 50);
                end
                run_left--;
                result_stall <= run_stalled;
            end
        end
    end

    // every accepted service against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_services.size() == 0)
            begin
                $error("service with none predicted: cylinder %0d movement %0d",
                       result_item.served_cylinder, result_item.movement_so_far);
                fail_count++;
            end
            else
            begin
                want = expected_services.pop_front();
                results_checked++;
                if (result_item.served_cylinder !== want.served_cylinder)
                begin
                    $error("served_cylinder: expected %0d, got %0d",
                           want.served_cylinder, result_item.served_cylinder);
                    fail_count++;
                end
                if (result_item.movement_so_far !== want.movement_so_far)
                begin
                    $error("movement_so_far: expected %0d, got %0d",
                           want.movement_so_far, result_item.movement_so_far);
                    fail_count++;
                end
                if (result_item.final_served !== want.final_served)
                begin
                    $error("final_served: expected %0d, got %0d",
                           want.final_served, result_item.final_served);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit with %0d services outstanding",
                 expected_services.size());
        $display("** cscan_disk_scheduler_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        request_valid = 1'b0;
        request_item  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_START_HEAD;
        cfg_data      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        test_reset_config();
        test_clamp_both_directions();
        test_disk_size_extremes();
        test_empty_sweep_side();
        // pressure and corner handshakes
        test_full_store();
        test_result_backpressure();
        test_pause_until_drained();
        test_no_idle();
        // random part
        test_random_batches(190);

        // drain, then give the block time to show any stray service
        wait_idle();
        $display("covered %0d requests in %0d batches under %0d register settings",
                 requests_sent, batches_done, settings_done);
        $display("checked %0d services in c-scan order, %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("** cscan_disk_scheduler_unit: PASSED **");
        else
            $display("** cscan_disk_scheduler_unit: FAILED **");
        $finish;
    end

endmodule
